// File: src/cpfa_pkg.sv
// Shared types and constants of the cell pair face agglomerator.
// Used by cpfa_hash and cell_pair_face_agglomerator_unit; no dependencies.
package cpfa_pkg;

  // Fixed port widths.
  localparam int CELL_W     = 20;
  localparam int PROC_W     = 16;
  localparam int FACE_OUT_W = 10;

  // Width of the generation tag kept with every table entry.
  localparam int EPOCH_W = 4;

  // Multiplicative hash: key * 0x9E3779B97F4A7C15, then h ^= h >> 29.
  localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
  localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;
  localparam int          HASH_SHIFT  = 29;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_MY_PROC  = 1'b0,
    CFG_NBR_PROC = 1'b1
  } cfg_idx_t;

endpackage

// File: src/cpfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/cpfa_hash.sv
// Hash unit: one 32x32 multiplier reused over three steps to form the low
// bits of key * golden-ratio constant, then folds in the bits 29 above.
// Depends on cpfa_pkg.
module cpfa_hash #(
  parameter int KEY_W = 40,
  parameter int IDX_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [IDX_W-1:0] idx_o
);

  import cpfa_pkg::*;

  // Only the product bits that reach the folded index are kept.
  localparam int ACC_W = HASH_SHIFT + IDX_W;

  typedef enum logic [1:0] {
    STEP_LL = 2'd0,
    STEP_HL = 2'd1,
    STEP_LH = 2'd2
  } step_t;

  step_t             step_r;
  logic              busy_r;
  logic              done_r;
  logic [63:0]       key_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       prod;
  logic [ACC_W-1:0]  prod_acc;

  always_comb begin
    case (step_r)
      STEP_LL: begin
        mul_a = key_r[31:0];
        mul_b = HASH_MUL_LO;
      end
      STEP_HL: begin
        mul_a = key_r[63:32];
        mul_b = HASH_MUL_LO;
      end
      STEP_LH: begin
        mul_a = key_r[31:0];
        mul_b = HASH_MUL_HI;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_acc = prod[ACC_W-1:0];

  // The two cross products only matter above bit 32.
  always_comb begin
    if (step_r == STEP_LL) begin
      acc_nxt = prod_acc;
    end else begin
      acc_nxt = acc_r + (prod_acc << 32);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= STEP_LL;
    end else begin
      done_r <= !start_i && busy_r && (step_r == STEP_LH);
      if (start_i) begin
        busy_r <= 1'b1;
        step_r <= STEP_LL;
      end else if (busy_r) begin
        case (step_r)
          STEP_LL: step_r <= STEP_HL;
          STEP_HL: step_r <= STEP_LH;
          default: begin
            busy_r <= 1'b0;
            step_r <= STEP_LL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      key_r <= 64'(key_i);
    end
    if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done_o = done_r;
  assign idx_o  = acc_r[IDX_W-1:0] ^ acc_r[HASH_SHIFT +: IDX_W];

endmodule

// File: src/cell_pair_face_agglomerator_unit.sv
// Top level of the cell pair face agglomerator: sequencer, linear-probe
// pair table and output register. Depends on cpfa_pkg, cpfa_hash, cpfa_ram.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   input   | in_valid / in_ready    | local_cell, neighbour_cell, last_face
//   result  | out_valid / out_ready  | coarse_face, new_face, coarse_cell, overflow
//   config  | cfg_we                 | cfg_index, cfg_wdata
//
// An item whose first probe settles it passes through accept, three multiplier
// passes plus the done step in the hash unit, one read and one compare; each
// further probe of the table memory adds one more read and compare.
// After reset and after every 2**EPOCH_W-1 interfaces a clearing pass writes
// all TABLE_SLOTS entries; no word is accepted meanwhile.
// A stalled result only holds the block when the next result is ready.
// TABLE_SLOTS must be a power of two.
module cell_pair_face_agglomerator_unit #(
  parameter int MAX_COARSE_FACES = 1024,
  parameter int TABLE_SLOTS      = 2048,
  parameter int CELL_INDEX_BITS  = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  cpfa_pkg::cfg_idx_t                cfg_index,
  input  logic [cpfa_pkg::PROC_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cpfa_pkg::CELL_W-1:0]       in_local_cell,
  input  logic [cpfa_pkg::CELL_W-1:0]       in_neighbour_cell,
  input  logic                              in_last_face,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cpfa_pkg::FACE_OUT_W-1:0]   out_coarse_face,
  output logic                              out_new_face,
  output logic [cpfa_pkg::CELL_W-1:0]       out_coarse_cell,
  output logic                              out_overflow
);

  import cpfa_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int KEY_W  = 2 * CELL_INDEX_BITS;
  localparam int FACE_W = $clog2(MAX_COARSE_FACES);
  localparam int FC_W   = $clog2(MAX_COARSE_FACES + 1);
  localparam int WORD_W = EPOCH_W + KEY_W + FACE_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_CHECK = 5'b10000
  } state_t;

  state_t               state_r;
  logic [PROC_W-1:0]    my_proc_r;
  logic [PROC_W-1:0]    nbr_proc_r;
  logic [KEY_W-1:0]     key_r;
  logic [CELL_W-1:0]    loc_r;
  logic                 last_r;
  logic [IDX_W-1:0]     pos_r;
  logic [IDX_W-1:0]     probes_r;
  logic [FC_W-1:0]      face_count_r;
  logic [EPOCH_W-1:0]   epoch_r;
  logic [IDX_W-1:0]     clr_addr_r;

  logic                  out_valid_r;
  logic [FACE_OUT_W-1:0] out_face_r;
  logic                  out_new_r;
  logic [CELL_W-1:0]     out_cell_r;
  logic                  out_ovf_r;

  // Key formation.
  logic [31:0]                loc32;
  logic [31:0]                nbr32;
  logic [CELL_INDEX_BITS-1:0] loc_k;
  logic [CELL_INDEX_BITS-1:0] nbr_k;
  logic [KEY_W-1:0]           key_in;
  logic                       in_acc;

  // Hash unit and memory.
  logic               h_done;
  logic [IDX_W-1:0]   h_idx;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [WORD_W-1:0]  mem_rdata;

  // Probe decision.
  logic [EPOCH_W-1:0] rd_tag;
  logic [KEY_W-1:0]   rd_key;
  logic [FACE_W-1:0]  rd_face;
  logic               slot_empty;
  logic               key_hit;
  logic               room;
  logic               finish;
  logic               out_free;
  logic               insert;
  logic [31:0]        hit_face32;
  logic [31:0]        new_face32;

  assign loc32  = 32'(in_local_cell);
  assign nbr32  = 32'(in_neighbour_cell);
  assign loc_k  = loc32[CELL_INDEX_BITS-1:0];
  assign nbr_k  = nbr32[CELL_INDEX_BITS-1:0];
  // Master side puts its own cell first; equal numbers count as slave.
  assign key_in = (my_proc_r < nbr_proc_r) ? {loc_k, nbr_k} : {nbr_k, loc_k};

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  cpfa_hash #(
    .KEY_W (KEY_W),
    .IDX_W (IDX_W)
  ) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (in_acc),
    .key_i   (key_in),
    .done_o  (h_done),
    .idx_o   (h_idx)
  );

  cpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (pos_r),
    .rdata (mem_rdata)
  );

  // An entry belongs to the current interface only when its tag matches.
  assign rd_tag     = mem_rdata[WORD_W-1 -: EPOCH_W];
  assign rd_key     = mem_rdata[FACE_W +: KEY_W];
  assign rd_face    = mem_rdata[FACE_W-1:0];
  assign slot_empty = (rd_tag != epoch_r);
  assign key_hit    = (rd_key == key_r);
  assign room       = (face_count_r < FC_W'(MAX_COARSE_FACES));
  assign finish     = slot_empty || key_hit || (&probes_r);
  assign out_free   = !out_valid_r || out_ready;
  assign insert     = (state_r == S_CHECK) && slot_empty && room && out_free;
  assign hit_face32 = 32'(rd_face);
  assign new_face32 = 32'(face_count_r);

  assign mem_re = (state_r == S_PROBE);

  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = insert;
      mem_waddr = pos_r;
      mem_wdata = {epoch_r, key_r, face_count_r[FACE_W-1:0]};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_proc_r  <= '0;
      nbr_proc_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MY_PROC:  my_proc_r  <= cfg_wdata;
        CFG_NBR_PROC: nbr_proc_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      face_count_r <= '0;
      epoch_r      <= EPOCH_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == S_CHECK && finish && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (&clr_addr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (h_done) begin
            state_r <= S_PROBE;
          end
        end
        S_PROBE: begin
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (!finish) begin
            state_r <= S_PROBE;
          end else if (out_free) begin
            if (last_r) begin
              face_count_r <= '0;
              if (&epoch_r) begin
                epoch_r <= EPOCH_W'(1);
                state_r <= S_CLEAR;
              end else begin
                epoch_r <= epoch_r + 1'b1;
                state_r <= S_IDLE;
              end
            end else begin
              if (insert) begin
                face_count_r <= face_count_r + 1'b1;
              end
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r  <= key_in;
      loc_r  <= in_local_cell;
      last_r <= in_last_face;
    end
    if (state_r == S_HASH && h_done) begin
      pos_r    <= h_idx;
      probes_r <= '0;
    end else if (state_r == S_CHECK && !finish) begin
      pos_r    <= pos_r + 1'b1;
      probes_r <= probes_r + 1'b1;
    end
    if (state_r == S_CHECK && finish && out_free) begin
      if (slot_empty) begin
        out_face_r <= room ? new_face32[FACE_OUT_W-1:0] : '0;
        out_new_r  <= room;
        out_cell_r <= room ? loc_r : '0;
        out_ovf_r  <= !room;
      end else if (key_hit) begin
        out_face_r <= hit_face32[FACE_OUT_W-1:0];
        out_new_r  <= 1'b0;
        out_cell_r <= '0;
        out_ovf_r  <= 1'b0;
      end else begin
        out_face_r <= '0;
        out_new_r  <= 1'b0;
        out_cell_r <= '0;
        out_ovf_r  <= 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coarse_face = out_face_r;
  assign out_new_face    = out_new_r;
  assign out_coarse_cell = out_cell_r;
  assign out_overflow    = out_ovf_r;

  a_new_xor_ovf : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_ovf_r))
    else $error("new face and overflow reported together");

  a_epoch_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("epoch reached the empty tag");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    face_count_r <= FC_W'(MAX_COARSE_FACES))
    else $error("face count beyond its limit");

  a_write_state : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CHECK || state_r == S_CLEAR))
    else $error("table written outside check or clear");

  a_hash_in_hash : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_HASH) ##3 h_done)
    else $error("hash result not back on time");

endmodule

// File: tb/cell_pair_face_agglomerator_unit_tb.sv
// Testbench for cell_pair_face_agglomerator_unit: face numbering over a hashed pair table.
// Depends on cpfa_pkg and the unit itself; predicts every result word in-line.
`timescale 1ns / 100ps

module cell_pair_face_agglomerator_unit_tb;
  import cpfa_pkg::*;

  localparam int FACE_LIMIT = 1024;
  localparam int PAIR_SLOTS = 2048;
  localparam int CELL_BITS = 20;
  // Worst quiet stretch: receiver hold-off, a clearing pass and a long probe chain.
  localparam int WATCHDOG_CYCLES = 20000;

  typedef struct packed {
    logic [FACE_OUT_W-1:0] coarse_face;
    logic                  new_face;
    logic [CELL_W-1:0]     coarse_cell;
    logic                  overflow;
  } face_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [PROC_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [CELL_W-1:0] in_local_cell;
  logic [CELL_W-1:0] in_neighbour_cell;
  logic in_last_face;
  logic out_valid;
  logic out_ready;
  logic [FACE_OUT_W-1:0] out_coarse_face;
  logic out_new_face;
  logic [CELL_W-1:0] out_coarse_cell;
  logic out_overflow;

  // Model of the pair table and the processor registers.
  logic [2*CELL_BITS-1:0] slot_key_q [PAIR_SLOTS];
  int unsigned slot_face_q [PAIR_SLOTS];
  bit slot_used_q [PAIR_SLOTS];
  int unsigned faces_made;
  logic [PROC_W-1:0] my_proc_q;
  logic [PROC_W-1:0] nbr_proc_q;

  face_result_t pending_faces [$];

  int unsigned failures = 0;
  int unsigned words_in = 0;
  int unsigned results_checked = 0;
  int unsigned faces_created = 0;
  int unsigned pair_hits = 0;
  int unsigned overflows = 0;
  int unsigned interfaces_closed = 0;
  int unsigned quiet_cycles = 0;
  int hold_remaining = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  cell_pair_face_agglomerator_unit #(
    .MAX_COARSE_FACES(FACE_LIMIT),
    .TABLE_SLOTS(PAIR_SLOTS),
    .CELL_INDEX_BITS(CELL_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_local_cell(in_local_cell),
    .in_neighbour_cell(in_neighbour_cell),
    .in_last_face(in_last_face),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_coarse_face(out_coarse_face),
    .out_new_face(out_new_face),
    .out_coarse_cell(out_coarse_cell),
    .out_overflow(out_overflow)
  );

  always #1 clk = ~clk;

  function automatic int unsigned slot_of(input logic [2*CELL_BITS-1:0] key);
    logic [63:0] h;
    h = {24'd0, key} * {HASH_MUL_HI, HASH_MUL_LO};
    h = h ^ (h >> HASH_SHIFT);
    return int'(h % PAIR_SLOTS);
  endfunction

  // Both sides of the interface must build the same key, so the master puts its own cell first.
  function automatic logic [2*CELL_BITS-1:0] pair_key(input logic [CELL_W-1:0] loc,
                                                      input logic [CELL_W-1:0] nbr);
    if (my_proc_q < nbr_proc_q) begin
      return {loc, nbr};
    end
    return {nbr, loc};
  endfunction

  function automatic void clear_pair_table();
    for (int i = 0; i < PAIR_SLOTS; i++) begin
      slot_used_q[i] = 1'b0;
    end
    faces_made = 0;
  endfunction

  function automatic face_result_t number_face(input logic [CELL_W-1:0] loc,
                                               input logic [CELL_W-1:0] nbr);
    face_result_t r;
    logic [2*CELL_BITS-1:0] key;
    int unsigned pos;
    int unsigned hit_face;
    bit found;
    bit have_free;
    key = pair_key(loc, nbr);
    pos = slot_of(key);
    found = 1'b0;
    have_free = 1'b0;
    hit_face = 0;
    for (int n = 0; n < PAIR_SLOTS && !found && !have_free; n++) begin
      if (!slot_used_q[pos]) begin
        have_free = 1'b1;
      end else if (slot_key_q[pos] == key) begin
        found = 1'b1;
        hit_face = slot_face_q[pos];
      end else begin
        pos = (pos + 1) % PAIR_SLOTS;
      end
    end
    r = '0;
    if (found) begin
      r.coarse_face = FACE_OUT_W'(hit_face);
    end else if (have_free && faces_made < FACE_LIMIT) begin
      slot_used_q[pos] = 1'b1;
      slot_key_q[pos] = key;
      slot_face_q[pos] = faces_made;
      r.coarse_face = FACE_OUT_W'(faces_made);
      r.new_face = 1'b1;
      r.coarse_cell = loc;
      faces_made++;
    end else begin
      r.overflow = 1'b1;
    end
    return r;
  endfunction

  // Predict at the edge where a word is accepted, and track register writes there too.
  always @(posedge clk) begin : predict_faces
    face_result_t want;
    if (!rst_n) begin
      clear_pair_table();
      my_proc_q = '0;
      nbr_proc_q = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MY_PROC: my_proc_q = cfg_wdata;
          CFG_NBR_PROC: nbr_proc_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = number_face(in_local_cell, in_neighbour_cell);
        pending_faces.push_back(want);
        words_in++;
        if (want.new_face) begin
          faces_created++;
        end else if (want.overflow) begin
          overflows++;
        end else begin
          pair_hits++;
        end
        if (in_last_face) begin
          clear_pair_table();
          interfaces_closed++;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    face_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_faces.size() == 0) begin
        $error("result word with nothing expected: coarse_face %0d", out_coarse_face);
        failures++;
      end else begin
        want = pending_faces.pop_front();
        results_checked++;
        if (out_coarse_face !== want.coarse_face) begin
          $error("coarse_face: expected %0d, got %0d", want.coarse_face, out_coarse_face);
          failures++;
        end
        if (out_new_face !== want.new_face) begin
          $error("new_face: expected %0d, got %0d", want.new_face, out_new_face);
          failures++;
        end
        if (out_coarse_cell !== want.coarse_cell) begin
          $error("coarse_cell: expected %0h, got %0h", want.coarse_cell, out_coarse_cell);
          failures++;
        end
        if (out_overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_overflow);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("** cell_pair_face_agglomerator_unit: FAILED **");
      $finish;
    end
  end

  // Mostly no gap, some short ones and now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  initial begin : drive_out_ready
    int unsigned stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_remaining > 0) begin
        out_ready = 1'b0;
        hold_remaining--;
      end else if (stall != 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (out_idle_on && $urandom_range(0, 2) == 0) begin
        stall = pick_gap();
        if (stall != 0) begin
          stall--;
        end
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_face(input logic [CELL_W-1:0] loc, input logic [CELL_W-1:0] nbr,
                           input logic is_last);
    int unsigned gap;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_local_cell = loc;
    in_neighbour_cell = nbr;
    in_last_face = is_last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic close_and_drain();
    in_valid = 1'b0;
    while (pending_faces.size() != 0) @(negedge clk);
  endtask

  task automatic set_processors(input logic [PROC_W-1:0] mine, input logic [PROC_W-1:0] theirs);
    cfg_we = 1'b1;
    cfg_index = CFG_MY_PROC;
    cfg_wdata = mine;
    @(negedge clk);
    cfg_index = CFG_NBR_PROC;
    cfg_wdata = theirs;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // First local cell at or after start whose pair with nbr hashes to the given slot.
  function automatic logic [CELL_W-1:0] find_cell_for_slot(input int unsigned target,
                                                           input logic [CELL_W-1:0] nbr,
                                                           input logic [CELL_W-1:0] start);
    logic [CELL_W-1:0] loc;
    loc = start;
    while (slot_of(pair_key(loc, nbr)) != target) begin
      loc++;
    end
    return loc;
  endfunction

  function automatic logic [CELL_W-1:0] rand_cell();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2: return CELL_W'($urandom_range(0, 15));
      3: return CELL_W'(20'hFFFFF - $urandom_range(0, 15));
      default: return CELL_W'($urandom);
    endcase
  endfunction

  // One interface: mostly repeats of pairs seen earlier, some fresh pairs, some reversed.
  task automatic run_interface(input int unsigned length, input bit close);
    logic [CELL_W-1:0] pool_loc [$];
    logic [CELL_W-1:0] pool_nbr [$];
    logic [CELL_W-1:0] a;
    logic [CELL_W-1:0] b;
    int unsigned k;
    int unsigned r;
    for (int unsigned i = 0; i < length; i++) begin
      r = $urandom_range(0, 99);
      if (pool_loc.size() != 0 && r < 60) begin
        k = $urandom_range(0, pool_loc.size() - 1);
        if (r < 6) begin
          a = pool_nbr[k];
          b = pool_loc[k];
        end else begin
          a = pool_loc[k];
          b = pool_nbr[k];
        end
      end else begin
        a = rand_cell();
        b = ($urandom_range(0, 19) == 0) ? a : rand_cell();
        pool_loc.push_back(a);
        pool_nbr.push_back(b);
      end
      send_face(a, b, close && (i == length - 1));
    end
  endtask

  task automatic test_directed_cases();
    logic [CELL_W-1:0] n;
    logic [CELL_W-1:0] c1;
    logic [CELL_W-1:0] c2;
    logic [CELL_W-1:0] w1;
    logic [CELL_W-1:0] w2;
    // Registers still at reset: equal processor numbers, so neighbour cell goes first.
    send_face(20'h00000, 20'h00000, 1'b0);
    send_face(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_face(20'h00000, 20'hFFFFF, 1'b0);
    send_face(20'hFFFFF, 20'h00000, 1'b0);
    send_face(20'h00000, 20'hFFFFF, 1'b0);
    send_face(20'hFFFFF, 20'h00000, 1'b1);
    close_and_drain();
    set_processors(16'h0000, 16'hFFFF);
    send_face(20'hAAAAA, 20'h55555, 1'b0);
    send_face(20'h55555, 20'hAAAAA, 1'b0);
    send_face(20'hAAAAA, 20'h55555, 1'b0);
    // Two pairs on the same home slot: the second one needs a further probe.
    n = 20'h12345;
    c1 = 20'h0ABCD;
    c2 = find_cell_for_slot(slot_of(pair_key(c1, n)), n, c1 + 1'b1);
    send_face(c1, n, 1'b0);
    send_face(c2, n, 1'b0);
    send_face(c2, n, 1'b0);
    send_face(c1, n, 1'b0);
    // Two pairs on the top slot, so probing wraps round to slot zero.
    w1 = find_cell_for_slot(PAIR_SLOTS - 1, n, '0);
    w2 = find_cell_for_slot(PAIR_SLOTS - 1, n, w1 + 1'b1);
    send_face(w1, n, 1'b0);
    send_face(w2, n, 1'b0);
    send_face(w2, n, 1'b1);
    close_and_drain();
    set_processors(16'hFFFF, 16'h0000);
    send_face(20'h00001, 20'h00002, 1'b0);
    send_face(20'h00003, 20'h00004, 1'b1);
    send_face(20'h00003, 20'h00004, 1'b0);
    send_face(20'h00001, 20'h00002, 1'b1);
  endtask

  // Fill the face counter, keep offering new pairs past it, and mix in repeats throughout.
  task automatic test_face_limit();
    logic [CELL_W-1:0] locs [$];
    logic [CELL_W-1:0] nbrs [$];
    logic [CELL_W-1:0] base;
    logic [CELL_W-1:0] loc;
    logic [CELL_W-1:0] nbr;
    int unsigned k;
    close_and_drain();
    set_processors(16'd1234, 16'd4321);
    base = CELL_W'($urandom);
    for (int unsigned i = 0; i < FACE_LIMIT + 40; i++) begin
      loc = base + CELL_W'(i * 7);
      nbr = CELL_W'($urandom);
      send_face(loc, nbr, 1'b0);
      locs.push_back(loc);
      nbrs.push_back(nbr);
      if (i % 16 == 15) begin
        k = $urandom_range(0, locs.size() - 1);
        send_face(locs[k], nbrs[k], 1'b0);
      end
    end
    k = $urandom_range(0, FACE_LIMIT - 1);
    send_face(locs[k], nbrs[k], 1'b1);
  endtask

  task automatic test_random_interfaces();
    logic [PROC_W-1:0] mine [8];
    logic [PROC_W-1:0] theirs [8];
    int unsigned used;
    int unsigned len;
    int unsigned r;
    bit open_end;
    mine = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0007, 16'h0008,
             16'($urandom), 16'($urandom)};
    theirs = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0008, 16'h0007,
               16'($urandom), 16'($urandom)};
    for (int p = 0; p < 8; p++) begin
      close_and_drain();
      set_processors(mine[p], theirs[p]);
      used = 0;
      while (used < 20) begin
        in_idle_on = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 99);
        if (r < 80) begin
          len = $urandom_range(1, 30);
        end else if (r < 95) begin
          len = $urandom_range(31, 80);
        end else begin
          len = $urandom_range(81, 200);
        end
        used += len;
        // Sometimes the table stays open across a change of processor numbers.
        open_end = (used >= 20) && ($urandom_range(0, 2) == 0);
        run_interface(len, !open_end);
      end
    end
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    close_and_drain();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    hold_remaining = 300;
    run_interface(80, 1'b1);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MY_PROC;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_local_cell = '0;
    in_neighbour_cell = '0;
    in_last_face = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_face_limit();
    test_random_interfaces();
    test_backpressure();

    close_and_drain();
    repeat (100) @(negedge clk);
    $display("Sent %0d words over %0d closed interfaces; checked %0d results.",
             words_in, interfaces_closed, results_checked);
    $display("Outcomes: %0d new faces, %0d pair hits, %0d overflows.",
             faces_created, pair_hits, overflows);
    if (failures == 0) begin
      $display("** cell_pair_face_agglomerator_unit: PASSED **");
    end else begin
      $display("** cell_pair_face_agglomerator_unit: FAILED **");
    end
    $finish;
  end

endmodule
